[hw/rtl/sle_pkg.sv]
package sle_pkg;

    localparam logic [7:0] QUOTE_DOUBLE = 8'h22;
    localparam logic [7:0] QUOTE_SINGLE = 8'h27;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5c;
    localparam logic [7:0] CHAR_NL      = 8'h0a;
    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LOW_N   = 8'h6e;
    localparam logic [7:0] CHAR_LOW_R   = 8'h72;
    localparam logic [7:0] CHAR_LOW_T   = 8'h74;
    localparam logic [7:0] CHAR_LOW_X   = 8'h78;
    localparam logic [7:0] CTRL_MAX     = 8'h1f;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Position within one item's expansion: up to six bytes
    localparam int IDX_W = 3;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_PLAIN,
        BODY_ESC,
        BODY_HEX
    } body_kind_t;

    typedef struct packed {
        logic       open;
        logic       close;
        logic [7:0] quote;
        body_kind_t kind;
        logic [7:0] ch;
    } item_desc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] v;
        v = {4'h0, n};
        if (n < 4'd10)
            return 8'h30 + v;
        else
            return 8'h57 + v;
    endfunction

endpackage

[hw/rtl/sle_front.sv]
module sle_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                has_byte,
    input  logic                end_of_string,
    output logic                push,
    output sle_pkg::item_desc_t push_desc,
    input  logic                q_full
);

    logic use_single_reg;
    logic inside_reg;
    logic inside_next;
    logic accept;
    logic [7:0] quote;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign quote    = use_single_reg ? sle_pkg::QUOTE_SINGLE : sle_pkg::QUOTE_DOUBLE;

    always_comb
    begin
        push_desc.open  = !inside_reg;
        push_desc.close = end_of_string;
        push_desc.quote = quote;
        push_desc.kind  = sle_pkg::BODY_NONE;
        push_desc.ch    = in_byte;
        if (has_byte)
        begin
            if (in_byte == quote || in_byte == sle_pkg::CHAR_BSLASH)
            begin
                push_desc.kind = sle_pkg::BODY_ESC;
            end
            else if (in_byte == sle_pkg::CHAR_NL)
            begin
                push_desc.kind = sle_pkg::BODY_ESC;
                push_desc.ch   = sle_pkg::CHAR_LOW_N;
            end
            else if (in_byte == sle_pkg::CHAR_CR)
            begin
                push_desc.kind = sle_pkg::BODY_ESC;
                push_desc.ch   = sle_pkg::CHAR_LOW_R;
            end
            else if (in_byte == sle_pkg::CHAR_TAB)
            begin
                push_desc.kind = sle_pkg::BODY_ESC;
                push_desc.ch   = sle_pkg::CHAR_LOW_T;
            end
            else if (in_byte <= sle_pkg::CTRL_MAX)
            begin
                push_desc.kind = sle_pkg::BODY_HEX;
            end
            else
            begin
                push_desc.kind = sle_pkg::BODY_PLAIN;
            end
        end
    end

    // Drop items that expand to nothing (empty item inside an open string)
    assign push = accept &&
                  (push_desc.open || push_desc.close || push_desc.kind != sle_pkg::BODY_NONE);

    always_comb
    begin
        inside_next = inside_reg;
        if (accept)
            inside_next = !end_of_string;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_single_reg <= 1'b0;
            inside_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                use_single_reg <= cfg_wdata;
            inside_reg <= inside_next;
        end
    end

endmodule

[hw/rtl/sle_queue.sv]
module sle_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sle_pkg::item_desc_t push_desc,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output sle_pkg::item_desc_t head_desc
);

    sle_pkg::item_desc_t         mem [sle_pkg::QDEPTH];
    logic [sle_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [sle_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [sle_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == sle_pkg::QCNT_W'(sle_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

endmodule

[hw/rtl/sle_back.sv]
module sle_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  sle_pkg::item_desc_t head_desc,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last
);

    logic [sle_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [sle_pkg::IDX_W-1:0] body_len;
    logic [sle_pkg::IDX_W-1:0] total;
    logic [sle_pkg::IDX_W-1:0] bidx;
    logic [7:0]                body [4];
    logic [7:0]                sel_byte;
    logic                      sel_last;
    logic                      at_end;
    logic                      load;
    logic                      valid_reg, valid_next;
    logic [7:0]                byte_reg;
    logic                      last_reg;

    always_comb
    begin
        body[0] = head_desc.ch;
        body[1] = head_desc.ch;
        body[2] = sle_pkg::hex_digit(head_desc.ch[7:4]);
        body[3] = sle_pkg::hex_digit(head_desc.ch[3:0]);
        body_len = '0;
        case (head_desc.kind)
            sle_pkg::BODY_PLAIN:
            begin
                body_len = 3'd1;
            end
            sle_pkg::BODY_ESC:
            begin
                body_len = 3'd2;
                body[0]  = sle_pkg::CHAR_BSLASH;
            end
            sle_pkg::BODY_HEX:
            begin
                body_len = 3'd4;
                body[0]  = sle_pkg::CHAR_BSLASH;
                body[1]  = sle_pkg::CHAR_LOW_X;
            end
            default:
            begin
                body_len = '0;
            end
        endcase
    end

    assign total = body_len + {2'b00, head_desc.open} + {2'b00, head_desc.close};
    assign bidx  = idx_reg - {2'b00, head_desc.open};

    always_comb
    begin
        if (head_desc.open && idx_reg == '0)
            sel_byte = head_desc.quote;
        else if (bidx < body_len)
            sel_byte = body[bidx[1:0]];
        else
            sel_byte = head_desc.quote;
    end

    assign at_end   = (idx_reg == total - 1'b1);
    assign sel_last = head_desc.close && at_end;

    // Advance when the output register is empty or being drained
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            last_reg <= sel_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < total))
        else $error("expansion index beyond item length");

    a_last_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |->
            (out_byte == sle_pkg::QUOTE_SINGLE || out_byte == sle_pkg::QUOTE_DOUBLE))
        else $error("closing byte is not a quote");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_byte) && $stable(last)))
        else $error("output item changed while stalled");

endmodule

[hw/rtl/string_literal_escaper_core.sv]
// An accepted item reaches the output through the descriptor queue, then the output register.
// Throughput: one output byte per cycle from the back-end sequencer unless m_tready stalls it;
// an item expands to 1 to 6 bytes; plain bytes run 1 item/cycle when the output is not stalled.
// A 4-entry descriptor queue lets input continue while escapes expand.
// Reset (rst_n, async, active low) clears the mode to double quotes, closes any open string,
// and empties the queue and output register.
module string_literal_escaper_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,    // use_single_quote
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] in_byte
    input  logic       s_tuser,      // has_byte
    input  logic       s_tlast,      // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tlast       // last
);

    logic                push;
    logic                q_full;
    logic                pop;
    logic                head_valid;
    sle_pkg::item_desc_t push_desc;
    sle_pkg::item_desc_t head_desc;

    sle_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .has_byte      (s_tuser),
        .end_of_string (s_tlast),
        .push          (push),
        .push_desc     (push_desc),
        .q_full        (q_full)
    );

    sle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    sle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .last       (m_tlast)
    );

endmodule

[test/escape_checker.sv]
module escape_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } lit_byte_t;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    lit_byte_t literal_q[$];
    logic      single_mode;
    logic      string_open;

    task automatic add_lit(input logic [7:0] c, input logic is_last);
        lit_byte_t lit;
        lit.ch    = c;
        lit.last  = is_last;
        literal_q = {literal_q, lit};
    endtask

    // Expand one accepted item into the literal bytes it must produce
    task automatic escape_item(input logic [7:0] b, input logic has, input logic eos);
        logic [7:0] q;
        q = single_mode ? sle_pkg::QUOTE_SINGLE : sle_pkg::QUOTE_DOUBLE;
        if (!string_open)
        begin
            add_lit(q, 1'b0);
            string_open = 1'b1;
        end
        if (has)
        begin
            if (b == q || b == sle_pkg::CHAR_BSLASH)
            begin
                add_lit(sle_pkg::CHAR_BSLASH, 1'b0);
                add_lit(b, 1'b0);
            end
            else if (b == sle_pkg::CHAR_NL)
            begin
                add_lit(sle_pkg::CHAR_BSLASH, 1'b0);
                add_lit(sle_pkg::CHAR_LOW_N, 1'b0);
            end
            else if (b == sle_pkg::CHAR_CR)
            begin
                add_lit(sle_pkg::CHAR_BSLASH, 1'b0);
                add_lit(sle_pkg::CHAR_LOW_R, 1'b0);
            end
            else if (b == sle_pkg::CHAR_TAB)
            begin
                add_lit(sle_pkg::CHAR_BSLASH, 1'b0);
                add_lit(sle_pkg::CHAR_LOW_T, 1'b0);
            end
            else if (b <= sle_pkg::CTRL_MAX)
            begin
                add_lit(sle_pkg::CHAR_BSLASH, 1'b0);
                add_lit(sle_pkg::CHAR_LOW_X, 1'b0);
                add_lit(HEX_CHARS[b[7:4]], 1'b0);
                add_lit(HEX_CHARS[b[3:0]], 1'b0);
            end
            else
                add_lit(b, 1'b0);
        end
        if (eos)
        begin
            add_lit(q, 1'b1);
            string_open = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lit_byte_t want;
        if (!rst_n)
        begin
            literal_q.delete();
            single_mode = 1'b0;
            string_open = 1'b0;
            pending     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (literal_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no byte, got byte %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = literal_q.pop_front();
                    if (want.ch !== m_tdata || want.last !== m_tlast)
                    begin
                        fail_count++;
                        $display("%0t: expected byte %h last %b, got byte %h last %b",
                                 $time, want.ch, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                escape_item(s_tdata, s_tuser, s_tlast);
            if (cfg_we)
                single_mode = cfg_wdata;
            pending = literal_q.size();
        end
    end

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 45;

    localparam logic [7:0] EDGE_BYTES [12] = '{
        8'h00, sle_pkg::CHAR_TAB, sle_pkg::CHAR_NL, sle_pkg::CHAR_CR, sle_pkg::CTRL_MAX,
        8'h20, sle_pkg::QUOTE_DOUBLE, sle_pkg::QUOTE_SINGLE, sle_pkg::CHAR_BSLASH,
        8'h7f, 8'h80, 8'hff
    };

    localparam logic PHASE_MODES [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int fail_count;
    int pending;
    int cycle_count;
    int burst_left;
    int items_sent;
    int stall_left;
    int stall_mode;

    string_literal_escaper_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    escape_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: switch at random between four stall patterns
    always @(negedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_item(input logic [7:0] b, input logic has, input logic eos);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
        if (has || eos)
            items_sent++;
    endtask

    // Drop valid, wait for every expected byte, then let the pipe settle
    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic single);
        go_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= single;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return EDGE_BYTES[4'($urandom_range(0, 11))];
            3, 4:    return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_string();
        int  len;
        bit  close_empty;
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        close_empty = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
        begin
            // noise: empty items, opening or inside a string
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(pick_byte(), 1'b1, (i == len - 1) && !close_empty);
        end
        if (len == 0 || close_empty)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int   target;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cycle_count = 0;
        burst_left  = 0;
        items_sent  = 0;
        stall_left  = 0;
        stall_mode  = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty string, byte field ignored
        send_item(8'ha5, 1'b0, 1'b1);
        foreach (EDGE_BYTES[i])
            send_item(EDGE_BYTES[i], 1'b1, i == 11);
        // empty item opens a string, a second one inside it gives nothing
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        // switch quote style while the string is still open
        write_mode(1'b1);
        send_item(sle_pkg::QUOTE_DOUBLE, 1'b1, 1'b0);
        send_item(sle_pkg::QUOTE_SINGLE, 1'b1, 1'b0);
        send_item(sle_pkg::CHAR_BSLASH, 1'b1, 1'b1);
        send_item(sle_pkg::CHAR_BSLASH, 1'b0, 1'b1);

        foreach (PHASE_MODES[p])
        begin
            write_mode(PHASE_MODES[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_string();
        end

        go_idle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
